[hw/rtl/pin_gated_drive_command_parser_assert.svh]
// Assertion macros used by the RTL of the drive command parser.
// Every use needs signals named clk and rst_n in the enclosing module.
`ifndef PIN_GATED_DRIVE_COMMAND_PARSER_ASSERT_SVH
`define PIN_GATED_DRIVE_COMMAND_PARSER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PGDCP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pgdcp assertion failed");
`define PGDCP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pgdcp assertion failed");
`else
`define PGDCP_ASSERT(lbl, prop)
`define PGDCP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hw/rtl/pgdcp_pkg.sv]
// Package for the drive command parser: item and result types, frame
// positions, character and drive codes, and the drive decode function.
// Depends on nothing.
package pgdcp_pkg;

  localparam logic [7:0] CH_START = 8'h5E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] CH_W     = 8'h57;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_A     = 8'h41;

  localparam logic [31:0] PIN_RESET = 32'h3132_3231;

  localparam logic        CMD_BYTE = 1'b0;
  localparam logic        CMD_TICK = 1'b1;

  localparam logic [2:0] DRV_STOP    = 3'd0;
  localparam logic [2:0] DRV_FWD     = 3'd1;
  localparam logic [2:0] DRV_REV     = 3'd2;
  localparam logic [2:0] DRV_CW      = 3'd3;
  localparam logic [2:0] DRV_CCW     = 3'd4;
  localparam logic [2:0] DRV_AUTO    = 3'd5;
  localparam logic [2:0] DRV_ARRIVED = 3'd6;
  localparam logic [2:0] DRV_NONE    = 3'd7;

  typedef enum logic [3:0] {
    FP_HUNT = 4'd0,
    FP_PIN1 = 4'd1,
    FP_PIN2 = 4'd2,
    FP_PIN3 = 4'd3,
    FP_PIN4 = 4'd4,
    FP_DIR  = 4'd5,
    FP_HUND = 4'd6,
    FP_TENS = 4'd7,
    FP_LAST = 4'd8
  } fpos_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic        accepted;
    logic        frame_done;
    logic [7:0]  command;
    logic [2:0]  drive;
    logic [15:0] set_time;
    logic [15:0] elapsed;
    logic [7:0]  pad_code;
    logic [15:0] intercept_kind;
    logic        course_begun;
  } res_t;

  function automatic logic [2:0] drive_of(input logic [7:0] c, input logic [7:0] pad);
    logic [2:0] d;
    case (c)
      CH_W:    d = DRV_STOP;
      CH_F:    d = DRV_FWD;
      CH_B:    d = DRV_REV;
      CH_R:    d = DRV_CW;
      CH_L:    d = DRV_CCW;
      CH_I:    d = DRV_AUTO;
      CH_E:    d = DRV_AUTO;
      CH_A:    d = (pad == CH_EIGHT) ? DRV_AUTO : DRV_ARRIVED;
      default: d = DRV_NONE;
    endcase
    return d;
  endfunction

endpackage

[hw/rtl/pgdcp_core.sv]
// Parser state and its one-pass update for each item: frame hunt, command,
// timer and timeout check. Depends on pgdcp_pkg and the assertion header.
`include "pin_gated_drive_command_parser_assert.svh"

module pgdcp_core
  import pgdcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  item_t       item,
  input  logic [31:0] pin_code,
  output res_t        res
);

  localparam logic [15:0] TIME_BIAS = 16'(CH_ZERO) * 16'd111;

  fpos_t       fp_r, fp_nxt;
  logic [7:0]  dir_r, dir_nxt;
  logic [7:0]  hund_r, hund_nxt;
  logic [7:0]  tens_r, tens_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [15:0] dur_r, dur_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [7:0]  pad_r, pad_nxt;
  logic [15:0] icpt_r, icpt_nxt;
  logic        started_r, started_nxt;
  logic        acc, done;
  logic [7:0]  b;
  logic [7:0]  pin_sel;
  logic [15:0] dur_calc;

  assign b = item.rx_byte;
  assign dur_calc = 16'(hund_r) * 16'd100 + 16'(tens_r) * 16'd10 + 16'(b) - TIME_BIAS;

  always_comb begin
    case (fp_r)
      FP_PIN1: pin_sel = pin_code[31:24];
      FP_PIN2: pin_sel = pin_code[23:16];
      FP_PIN3: pin_sel = pin_code[15:8];
      default: pin_sel = pin_code[7:0];
    endcase
  end

  always_comb begin
    fp_nxt      = fp_r;
    dir_nxt     = dir_r;
    hund_nxt    = hund_r;
    tens_nxt    = tens_r;
    cmd_nxt     = cmd_r;
    dur_nxt     = dur_r;
    tick_nxt    = tick_r;
    pad_nxt     = pad_r;
    icpt_nxt    = icpt_r;
    started_nxt = started_r;
    acc         = 1'b0;
    done        = 1'b0;
    if (fire) begin
      if (item.cmd == CMD_TICK) begin
        if (tick_r != 16'hFFFF) begin
          tick_nxt = tick_r + 16'd1;
        end
      end else if (cmd_r inside {CH_W, CH_A, CH_I}) begin
        acc = 1'b1;
        case (fp_r)
          FP_HUNT: begin
            if (b == CH_START) fp_nxt = FP_PIN1;
          end
          FP_PIN1, FP_PIN2, FP_PIN3, FP_PIN4: begin
            if (b == pin_sel) begin
              fp_nxt = fpos_t'(fp_r + 4'd1);
            end else begin
              fp_nxt = (b == CH_START) ? FP_PIN1 : FP_HUNT;
            end
          end
          FP_DIR: begin
            dir_nxt = b;
            fp_nxt  = FP_HUND;
          end
          FP_HUND: begin
            hund_nxt = b;
            fp_nxt   = FP_TENS;
          end
          FP_TENS: begin
            tens_nxt = b;
            fp_nxt   = FP_LAST;
          end
          FP_LAST: begin
            done        = 1'b1;
            cmd_nxt     = dir_r;
            tick_nxt    = 16'd0;
            dur_nxt     = dur_calc;
            started_nxt = 1'b1;
            fp_nxt      = FP_HUNT;
            if (dir_r == CH_A) pad_nxt = b;
            if (dir_r == CH_I) icpt_nxt = 16'(b) - 16'(CH_ZERO);
          end
          default: fp_nxt = FP_HUNT;
        endcase
      end
      // A timed move falls back to wait once its time has run out.
      if ((cmd_nxt inside {CH_F, CH_B, CH_R, CH_L}) && (tick_nxt >= dur_nxt)) begin
        cmd_nxt = CH_W;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fp_r      <= FP_HUNT;
      dir_r     <= 8'd0;
      hund_r    <= 8'd0;
      tens_r    <= 8'd0;
      cmd_r     <= CH_W;
      dur_r     <= 16'd0;
      tick_r    <= 16'd0;
      pad_r     <= CH_ZERO;
      icpt_r    <= 16'd0;
      started_r <= 1'b0;
    end else begin
      fp_r      <= fp_nxt;
      dir_r     <= dir_nxt;
      hund_r    <= hund_nxt;
      tens_r    <= tens_nxt;
      cmd_r     <= cmd_nxt;
      dur_r     <= dur_nxt;
      tick_r    <= tick_nxt;
      pad_r     <= pad_nxt;
      icpt_r    <= icpt_nxt;
      started_r <= started_nxt;
    end
  end

  always_comb begin
    res.accepted       = acc;
    res.frame_done     = done;
    res.command        = cmd_nxt;
    res.drive          = drive_of(cmd_nxt, pad_nxt);
    res.set_time       = dur_nxt;
    res.elapsed        = tick_nxt;
    res.pad_code       = pad_nxt;
    res.intercept_kind = icpt_nxt;
    res.course_begun   = started_nxt;
  end

  `PGDCP_ASSERT(a_done_is_accepted, res.frame_done |-> res.accepted)
  `PGDCP_ASSERT(a_tick_not_accepted, (fire && item.cmd == CMD_TICK) |-> !res.accepted)
  `PGDCP_ASSERT_NEXT(a_frame_starts_course, fire && res.frame_done, started_r && fp_r == FP_HUNT)
  `PGDCP_ASSERT(a_timed_not_expired, (fire && (res.command == CH_F || res.command == CH_B || res.command == CH_R || res.command == CH_L)) |-> (res.elapsed < res.set_time))

endmodule

[hw/rtl/pin_gated_drive_command_parser.sv]
// Channel  Direction  Ports
// in       input      in_valid, in_ready, in_cmd, in_rx_byte
// out      output     out_valid, out_ready, out_accepted ... out_course_begun
// cfg      input      cfg_valid, cfg_ready, cfg_pin_code
// One item per cycle is sustained while out_ready is high; each item passes
// through the input register and then the result register before its result leaves.
// The PIN register is always ready and resets to "1221".
// Synchronous active-low reset clears the parser state and both valid flags.
// A stalled result register holds the input register, which stops in_ready.
// Top level of the drive command parser. Depends on pgdcp_pkg and pgdcp_core.
module pin_gated_drive_command_parser
  import pgdcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_accepted,
  output logic        out_frame_done,
  output logic [7:0]  out_command,
  output logic [2:0]  out_drive,
  output logic [15:0] out_set_time,
  output logic [15:0] out_elapsed,
  output logic [7:0]  out_pad_code,
  output logic [15:0] out_intercept_kind,
  output logic        out_course_begun,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_pin_code
);

  logic        in_vld_r;
  item_t       in_item_r;
  logic        out_vld_r;
  res_t        out_res_r;
  res_t        res;
  logic [31:0] pin_r;
  logic        advance;

  assign advance   = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      pin_r     <= PIN_RESET;
    end else begin
      if (in_ready) in_vld_r <= in_valid;
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_valid) pin_r <= cfg_pin_code;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r.cmd     <= in_cmd;
      in_item_r.rx_byte <= in_rx_byte;
    end
    if (advance) out_res_r <= res;
  end

  pgdcp_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (advance),
    .item     (in_item_r),
    .pin_code (pin_r),
    .res      (res)
  );

  assign out_valid          = out_vld_r;
  assign out_accepted       = out_res_r.accepted;
  assign out_frame_done     = out_res_r.frame_done;
  assign out_command        = out_res_r.command;
  assign out_drive          = out_res_r.drive;
  assign out_set_time       = out_res_r.set_time;
  assign out_elapsed        = out_res_r.elapsed;
  assign out_pad_code       = out_res_r.pad_code;
  assign out_intercept_kind = out_res_r.intercept_kind;
  assign out_course_begun   = out_res_r.course_begun;

endmodule
